>>> src/ppcrpe_pkg.sv
// Package for the PowerPC relocation patch engine.
// Holds the channel payload types, the decoded command type, relocation codes and opcodes.
// No dependencies; every other file of the block refers to it by scoped names.
package ppcrpe_pkg;

	// Depth of the command queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_LOAD_BASE      = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PLT_ADDRESS    = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INDIRECT_TABLE = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TEXT_SECTION   = 8'd3;

	// ELF PowerPC relocation types.
	localparam logic [7:0] RT_ADDR32    = 8'd1;
	localparam logic [7:0] RT_ADDR16_LO = 8'd4;
	localparam logic [7:0] RT_ADDR16_HI = 8'd5;
	localparam logic [7:0] RT_ADDR16_HA = 8'd6;
	localparam logic [7:0] RT_REL24     = 8'd10;
	localparam logic [7:0] RT_JMP_SLOT  = 8'd21;
	localparam logic [7:0] RT_RELATIVE  = 8'd22;

	// ELF symbol types.
	localparam logic [3:0] SK_NOTYPE = 4'd0;
	localparam logic [3:0] SK_OBJECT = 4'd1;
	localparam logic [3:0] SK_FUNC   = 4'd2;

	// Instruction encodings and masks.
	localparam logic [31:0] MASK_REL24 = 32'h03FF_FFFC;
	localparam logic [31:0] OPC_B      = 32'h4800_0000;
	localparam logic [31:0] OPC_LI_R0  = 32'h3800_0000;
	localparam logic [31:0] MASK_WORD  = 32'hFFFF_FFFF;
	localparam logic [31:0] MASK_HALF  = 32'h0000_FFFF;
	localparam logic [15:0] TABLE_STEP = 16'd4;

	// Input transaction.
	typedef struct packed {
		logic [7:0]         reloc_type;
		logic [31:0]        target_offset;
		logic [31:0]        symbol_value;
		logic [3:0]         symbol_kind;
		logic signed [31:0] addend;
	} in_item_t;

	// Result transaction.
	typedef struct packed {
		logic        write_enable;
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic        write_halfword;
		logic [31:0] write_bit_mask;
		logic        last_of_item;
	} result_t;

	// Configuration register values.
	typedef struct packed {
		logic [31:0] load_base;
		logic [31:0] plt_address;
		logic [31:0] indirect_table_address;
		logic [31:0] text_section_value;
	} cfg_t;

	// Operation the back part carries out for one relocation.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_WORD,
		OP_LO,
		OP_HI,
		OP_HA,
		OP_REL24,
		OP_BRANCH,
		OP_SLOT
	} op_t;

	// Decoded command: place is the patched address, val the operation's value.
	typedef struct packed {
		op_t         op;
		logic [31:0] place;
		logic [31:0] val;
	} cmd_t;

	// Steps of an object jump slot.
	typedef enum logic [1:0] {
		STEP_LI,
		STEP_BRANCH,
		STEP_TABLE
	} slot_step_t;

endpackage

>>> src/ppcrpe_front.sv
// Front part of the relocation patch engine: classifies a relocation and forms its sums.
// Depends on ppcrpe_pkg for the payload, command and configuration types.
module ppcrpe_front (
	input  ppcrpe_pkg::in_item_t item,
	input  ppcrpe_pkg::cfg_t     cfg,
	output ppcrpe_pkg::cmd_t     cmd
);

	logic        text_hit;
	logic [31:0] base_add;
	logic [31:0] sum_x;
	logic [31:0] sum_v;
	logic        rel24_ovf;

	// A symbol value equal to the text-section value counts as zero.
	assign text_hit = (item.symbol_value == cfg.text_section_value);

	// B+A, B+S+A and S+A-O, with S dropped on a text-section hit.
	assign base_add = cfg.load_base + item.addend;
	assign sum_x    = text_hit ? base_add : (base_add + item.symbol_value);
	assign sum_v    = text_hit ? (item.addend - item.target_offset)
	                           : (item.addend - item.target_offset + item.symbol_value);

	// A branch displacement that overflows in the positive direction is skipped.
	assign rel24_ovf = (sum_v[31:26] != 6'd0) && !sum_v[31];

	// Pick the operation and the value that the back part needs.
	always_comb begin
		cmd.place = cfg.load_base + item.target_offset;
		cmd.val   = sum_x;
		cmd.op    = ppcrpe_pkg::OP_NONE;
		unique case (item.reloc_type)
			ppcrpe_pkg::RT_RELATIVE: begin
				cmd.op  = ppcrpe_pkg::OP_WORD;
				cmd.val = base_add;
			end
			ppcrpe_pkg::RT_ADDR32:    cmd.op = ppcrpe_pkg::OP_WORD;
			ppcrpe_pkg::RT_ADDR16_LO: cmd.op = ppcrpe_pkg::OP_LO;
			ppcrpe_pkg::RT_ADDR16_HI: cmd.op = ppcrpe_pkg::OP_HI;
			ppcrpe_pkg::RT_ADDR16_HA: cmd.op = ppcrpe_pkg::OP_HA;
			ppcrpe_pkg::RT_REL24: begin
				cmd.val = sum_v;
				cmd.op  = rel24_ovf ? ppcrpe_pkg::OP_NONE : ppcrpe_pkg::OP_REL24;
			end
			ppcrpe_pkg::RT_JMP_SLOT: begin
				priority if (item.symbol_kind == ppcrpe_pkg::SK_NOTYPE ||
				             item.symbol_kind == ppcrpe_pkg::SK_FUNC) begin
					cmd.op  = ppcrpe_pkg::OP_BRANCH;
					cmd.val = sum_v;
				end else if (item.symbol_kind == ppcrpe_pkg::SK_OBJECT) begin
					cmd.op = ppcrpe_pkg::OP_SLOT;
				end else begin
					cmd.op = ppcrpe_pkg::OP_NONE;
				end
			end
			default: cmd.op = ppcrpe_pkg::OP_NONE;
		endcase
	end

endmodule

>>> src/ppcrpe_queue.sv
// Command queue between the front and back parts of the relocation patch engine.
// Depends on ppcrpe_pkg for the command type.
module ppcrpe_queue #(
	parameter int unsigned DEPTH = ppcrpe_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  ppcrpe_pkg::cmd_t wr_cmd,
	input  logic             rd,
	output ppcrpe_pkg::cmd_t rd_cmd,
	output logic             full,
	output logic             empty
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ppcrpe_pkg::cmd_t entries_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_cmd = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> src/ppcrpe_back.sv
// Back part of the relocation patch engine: turns commands into memory write results.
// Depends on ppcrpe_pkg; keeps the indirect table offset and the result register.
module ppcrpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ppcrpe_pkg::cfg_t    cfg,
	input  logic                hd_valid,
	input  ppcrpe_pkg::cmd_t    hd,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output ppcrpe_pkg::result_t result
);

	ppcrpe_pkg::slot_step_t step_q;
	ppcrpe_pkg::slot_step_t step_d;
	logic [15:0]            tbl_q;
	ppcrpe_pkg::result_t    res_q;
	ppcrpe_pkg::result_t    res_d;
	logic                   res_valid_q;
	logic                   load;
	logic                   is_slot;
	logic                   slot_done;
	logic [31:0]            place_p4;
	logic [31:0]            br_disp;

	// A new result is formed when the result register is free or being taken.
	assign load      = hd_valid && (!res_valid_q || pop);
	assign is_slot   = (hd.op == ppcrpe_pkg::OP_SLOT);
	assign slot_done = load && is_slot && (step_q == ppcrpe_pkg::STEP_TABLE);
	assign q_pop     = load && (!is_slot || step_q == ppcrpe_pkg::STEP_TABLE);
	assign empty     = !res_valid_q;
	assign result    = res_q;

	// The second slot word branches to the PLT from its own address: plt - place - 4.
	assign place_p4 = hd.place + 32'd4;
	assign br_disp  = cfg.plt_address + ~hd.place + 32'hFFFF_FFFD;

	// Result for the command at the head of the queue.
	always_comb begin
		res_d                = '0;
		res_d.write_enable   = 1'b1;
		res_d.write_address  = hd.place;
		res_d.write_data     = hd.val;
		res_d.write_bit_mask = ppcrpe_pkg::MASK_WORD;
		res_d.last_of_item   = 1'b1;
		unique case (hd.op)
			ppcrpe_pkg::OP_NONE: begin
				res_d              = '0;
				res_d.last_of_item = 1'b1;
			end
			ppcrpe_pkg::OP_WORD: ;
			ppcrpe_pkg::OP_LO: begin
				res_d.write_data     = {16'd0, hd.val[15:0]};
				res_d.write_halfword = 1'b1;
				res_d.write_bit_mask = ppcrpe_pkg::MASK_HALF;
			end
			ppcrpe_pkg::OP_HI: begin
				res_d.write_data     = {16'd0, hd.val[31:16]};
				res_d.write_halfword = 1'b1;
				res_d.write_bit_mask = ppcrpe_pkg::MASK_HALF;
			end
			ppcrpe_pkg::OP_HA: begin
				res_d.write_data     = {16'd0, hd.val[31:16] + 16'(hd.val[15])};
				res_d.write_halfword = 1'b1;
				res_d.write_bit_mask = ppcrpe_pkg::MASK_HALF;
			end
			ppcrpe_pkg::OP_REL24: begin
				res_d.write_data     = hd.val & ppcrpe_pkg::MASK_REL24;
				res_d.write_bit_mask = ppcrpe_pkg::MASK_REL24;
			end
			ppcrpe_pkg::OP_BRANCH: begin
				res_d.write_data = ppcrpe_pkg::OPC_B | (hd.val & ppcrpe_pkg::MASK_REL24);
			end
			ppcrpe_pkg::OP_SLOT: begin
				unique case (step_q)
					ppcrpe_pkg::STEP_LI: begin
						res_d.write_data   = ppcrpe_pkg::OPC_LI_R0 | {16'd0, tbl_q};
						res_d.last_of_item = 1'b0;
					end
					ppcrpe_pkg::STEP_BRANCH: begin
						res_d.write_address = place_p4;
						res_d.write_data    = ppcrpe_pkg::OPC_B |
						                      (br_disp & ppcrpe_pkg::MASK_REL24);
						res_d.last_of_item  = 1'b0;
					end
					ppcrpe_pkg::STEP_TABLE: begin
						res_d.write_address = cfg.indirect_table_address + {16'd0, tbl_q};
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Next step of an object jump slot.
	always_comb begin
		step_d = step_q;
		if (load && is_slot) begin
			unique case (step_q)
				ppcrpe_pkg::STEP_LI:     step_d = ppcrpe_pkg::STEP_BRANCH;
				ppcrpe_pkg::STEP_BRANCH: step_d = ppcrpe_pkg::STEP_TABLE;
				ppcrpe_pkg::STEP_TABLE:  step_d = ppcrpe_pkg::STEP_LI;
				default:                 step_d = ppcrpe_pkg::STEP_LI;
			endcase
		end
	end

	// Slot step and table offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ppcrpe_pkg::STEP_LI;
			tbl_q  <= '0;
		end else begin
			step_q <= step_d;
			if (slot_done) begin
				tbl_q <= tbl_q + ppcrpe_pkg::TABLE_STEP;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTH
	// Only an object slot can be in the middle of its steps.
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != ppcrpe_pkg::STEP_LI) |-> (hd_valid && hd.op == ppcrpe_pkg::OP_SLOT))
		else $error("slot step active without an object slot at the queue head");

	// The table offset moves only after the last word of an object slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tbl_q) |-> $past(slot_done))
		else $error("table offset changed outside an object slot");

	// A command leaves the queue exactly with the final result of its relocation.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> res_d.last_of_item)
		else $error("command retired on a result that is not the last");
`endif

endmodule

>>> src/ppc_relocation_patch_engine.sv
// Top level of the PowerPC relocation patch engine: configuration registers and wiring.
// Depends on ppcrpe_pkg, ppcrpe_front, ppcrpe_queue and ppcrpe_back.
//
//   channel   ports                             direction
//   input     push, full, in_item               in  (queue write side)
//   result    empty, pop, result                out (queue read side)
//   config    cfg_write, cfg_index, cfg_data    in  (write only, no wait)
//
// An item is classified and its sums formed in the cycle it is pushed, and it lands in a
// command queue of QUEUE_DEPTH entries (at least 2). The back part forms one result per
// cycle while the result register is free or being popped; an object jump slot yields
// three results and holds the queue head until the last. Results are registered, and the
// result register is refilled in the cycle it is popped; full rises only when the
// queue holds QUEUE_DEPTH commands. Reset clears the registers, the queue and the table offset.
module ppc_relocation_patch_engine #(
	parameter int unsigned QUEUE_DEPTH = ppcrpe_pkg::QUEUE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  ppcrpe_pkg::in_item_t                 in_item,
	output logic                                 empty,
	input  logic                                 pop,
	output ppcrpe_pkg::result_t                  result,
	input  logic                                 cfg_write,
	input  logic [ppcrpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                          cfg_data
);

	ppcrpe_pkg::cfg_t cfg_q;
	ppcrpe_pkg::cmd_t front_cmd;
	ppcrpe_pkg::cmd_t head_cmd;
	logic             q_empty;
	logic             q_pop;

	// Configuration registers; writes beyond the last index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ppcrpe_pkg::REG_LOAD_BASE:      cfg_q.load_base              <= cfg_data;
				ppcrpe_pkg::REG_PLT_ADDRESS:    cfg_q.plt_address            <= cfg_data;
				ppcrpe_pkg::REG_INDIRECT_TABLE: cfg_q.indirect_table_address <= cfg_data;
				ppcrpe_pkg::REG_TEXT_SECTION:   cfg_q.text_section_value     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classification of the incoming relocation.
	ppcrpe_front u_front (
		.item (in_item),
		.cfg  (cfg_q),
		.cmd  (front_cmd)
	);

	// Queue between classification and execution.
	ppcrpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wr_cmd (front_cmd),
		.rd     (q_pop),
		.rd_cmd (head_cmd),
		.full   (full),
		.empty  (q_empty)
	);

	// Execution into memory write results.
	ppcrpe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.hd_valid (!q_empty),
		.hd       (head_cmd),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
